[rtl/tfla_pkg.sv]
// Shared types, codes and constants of the ticket-ordered lane arbiter.
package tfla_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int CMD_W   = 3;
   localparam int IDENT_W = 32;
   localparam int INDEX_W = 8;
   localparam int RC_W    = 3;
   localparam int WAIT_W  = 4;

   localparam logic [CMD_W-1:0] CMD_REQUEST  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WITHDRAW = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd4;

   localparam logic [RC_W-1:0] RC_OK        = 3'd0;
   localparam logic [RC_W-1:0] RC_INVALID   = 3'd1;
   localparam logic [RC_W-1:0] RC_FULL      = 3'd2;
   localparam logic [RC_W-1:0] RC_EXHAUSTED = 3'd3;
   localparam logic [RC_W-1:0] RC_REFUSED   = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [IDENT_W-1:0] token_identity;
      logic [INDEX_W-1:0] token_index;
   } req_type;

   typedef struct packed {
      logic [RC_W-1:0]    result_code;
      logic [IDENT_W-1:0] granted_identity;
      logic [INDEX_W-1:0] granted_slot;
      logic               ticket_wrapped;
      logic [IDENT_W-1:0] holder_identity;
      logic [WAIT_W-1:0]  waiting_count;
   } rsp_type;

endpackage

[rtl/tfla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tfla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ticket_fifo_lane_arbiter.sv]
// Ticket-ordered arbiter for one shared lane: top level with slot sequencer.
// Sequencing: invalid/blank-check failures answer in the cycle after the beat; request
//   scans for a free slot, one slot a cycle; acquire, withdraw and release read the
//   slot and compare, and acquire then scans all slots for an older one; status scans all.
// Throughput: one beat at a time; busy stays high until rsp_strobe; receiver cannot stall.
// Reset: all slots free, ticket counter one, no holder, rsp_strobe low.
module ticket_fifo_lane_arbiter #(
   parameter int SLOTS = tfla_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tfla_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output tfla_pkg::rsp_type rsp_payload
);

   localparam int SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SlotIdxW-1:0] LastSlot = SlotIdxW'(SLOTS - 1);
   localparam logic [tfla_pkg::INDEX_W-1:0] SlotsLimit = tfla_pkg::INDEX_W'(SLOTS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FREE  = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_SCAN  = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [tfla_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [tfla_pkg::IDENT_W-1:0]     ident_ff, ident_in;
   logic [tfla_pkg::INDEX_W-1:0]     idx_ff, idx_in;
   logic [SlotIdxW-1:0]              cnt_ff, cnt_in;
   logic                             issuing_ff, issuing_in;
   logic                             rd_live_ff, rd_live_in;
   logic [SlotIdxW-1:0]              rd_idx_ff, rd_idx_in;
   logic                             rd_last_ff, rd_last_in;
   logic                             older_ff, older_in;
   logic [tfla_pkg::IDENT_W-1:0]     act_ff, act_in;
   logic [tfla_pkg::WAIT_W-1:0]      wait_ff, wait_in;
   logic [SLOTS-1:0]                 valid_ff, valid_in;
   logic [tfla_pkg::IDENT_W-1:0]     ticket_ff, ticket_in;
   logic                             holder_valid_ff, holder_valid_in;
   logic [SlotIdxW-1:0]              holder_slot_ff, holder_slot_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   tfla_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             ram_we;
   logic [SlotIdxW-1:0]              ram_raddr;
   logic [tfla_pkg::IDENT_W-1:0]     ram_rdata;
   logic                             cmp_eq, cmp_lt;
   logic [SlotIdxW-1:0]              idx_slot;
   logic                             exact, is_hold, rd_valid, finish;
   logic [tfla_pkg::RC_W-1:0]        rc;
   logic [tfla_pkg::IDENT_W-1:0]     g_id;
   logic [tfla_pkg::INDEX_W-1:0]     g_slot;

   tfla_ram #(
      .WIDTH (tfla_pkg::IDENT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff),
      .wr_data (ticket_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared comparator: stored identity against the token identity
   assign cmp_eq = (ram_rdata == ident_ff);
   assign cmp_lt = (ram_rdata < ident_ff);

   assign idx_slot = idx_ff[SlotIdxW-1:0];
   assign exact    = valid_ff[idx_slot] && cmp_eq;
   assign is_hold  = holder_valid_ff && (holder_slot_ff == idx_slot);
   assign rd_valid = valid_ff[rd_idx_ff];

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      ident_in        = ident_ff;
      idx_in          = idx_ff;
      cnt_in          = cnt_ff;
      issuing_in      = 1'b0;
      rd_live_in      = 1'b0;
      rd_idx_in       = cnt_ff;
      rd_last_in      = 1'b0;
      older_in        = older_ff;
      act_in          = act_ff;
      wait_in         = wait_ff;
      valid_in        = valid_ff;
      ticket_in       = ticket_ff;
      holder_valid_in = holder_valid_ff;
      holder_slot_in  = holder_slot_ff;
      ram_we          = 1'b0;
      ram_raddr       = cnt_ff;
      finish          = 1'b0;
      rc              = tfla_pkg::RC_INVALID;
      g_id            = '0;
      g_slot          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_payload.command;
               ident_in = req_payload.token_identity;
               idx_in   = req_payload.token_index;
               cnt_in   = '0;
               older_in = 1'b0;
               act_in   = '0;
               wait_in  = '0;
               unique case (req_payload.command)
                  tfla_pkg::CMD_REQUEST: begin
                     if (req_payload.token_identity != '0 || req_payload.token_index != '0) begin
                        finish = 1'b1;
                        rc     = tfla_pkg::RC_INVALID;
                     end else if (ticket_ff == '0) begin
                        finish = 1'b1;
                        rc     = tfla_pkg::RC_EXHAUSTED;
                     end else begin
                        state_in = ST_FREE;
                     end
                  end
                  tfla_pkg::CMD_ACQUIRE, tfla_pkg::CMD_WITHDRAW,
                  tfla_pkg::CMD_RELEASE: begin
                     if (req_payload.token_identity == '0 ||
                         req_payload.token_index >= SlotsLimit) begin
                        finish = 1'b1;
                        rc     = tfla_pkg::RC_REFUSED;
                     end else begin
                        state_in = ST_LOOK;
                     end
                  end
                  tfla_pkg::CMD_STATUS: begin
                     state_in   = ST_SCAN;
                     issuing_in = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                     rc     = tfla_pkg::RC_INVALID;
                  end
               endcase
            end
         end
         ST_FREE: begin
            if (!valid_ff[cnt_ff]) begin
               ram_we           = 1'b1;
               valid_in[cnt_ff] = 1'b1;
               ticket_in        = ticket_ff + 1'b1;
               finish           = 1'b1;
               rc               = tfla_pkg::RC_OK;
               g_id             = ticket_ff;
               g_slot           = tfla_pkg::INDEX_W'(cnt_ff);
               state_in         = ST_IDLE;
            end else if (cnt_ff == LastSlot) begin
               finish   = 1'b1;
               rc       = tfla_pkg::RC_FULL;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LOOK: begin
            ram_raddr = idx_slot;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_IDLE;
            finish   = 1'b1;
            rc       = tfla_pkg::RC_REFUSED;
            unique case (cmd_ff)
               tfla_pkg::CMD_ACQUIRE: begin
                  if (exact && holder_valid_ff) begin
                     if (is_hold) begin
                        rc = tfla_pkg::RC_OK;
                     end
                  end else if (exact) begin
                     finish     = 1'b0;
                     state_in   = ST_SCAN;
                     issuing_in = 1'b1;
                  end
               end
               tfla_pkg::CMD_WITHDRAW: begin
                  if (exact && !is_hold) begin
                     valid_in[idx_slot] = 1'b0;
                     rc                 = tfla_pkg::RC_OK;
                  end
               end
               tfla_pkg::CMD_RELEASE: begin
                  if (exact && is_hold) begin
                     valid_in[idx_slot] = 1'b0;
                     holder_valid_in    = 1'b0;
                     rc                 = tfla_pkg::RC_OK;
                  end
               end
               default: begin
                  rc = tfla_pkg::RC_REFUSED;
               end
            endcase
         end
         ST_SCAN: begin
            // read issue runs one slot ahead of the compare
            if (issuing_ff) begin
               rd_live_in = 1'b1;
               rd_idx_in  = cnt_ff;
               rd_last_in = (cnt_ff == LastSlot);
               issuing_in = (cnt_ff != LastSlot);
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_live_ff && rd_valid) begin
               if (cmd_ff == tfla_pkg::CMD_STATUS) begin
                  if (holder_valid_ff && holder_slot_ff == rd_idx_ff) begin
                     act_in = ram_rdata;
                  end else begin
                     wait_in = wait_ff + 1'b1;
                  end
               end else if (cmp_lt) begin
                  older_in = 1'b1;
               end
            end
            if (rd_live_ff && rd_last_ff) begin
               state_in = ST_IDLE;
               finish   = 1'b1;
               if (cmd_ff == tfla_pkg::CMD_STATUS) begin
                  rc = tfla_pkg::RC_OK;
               end else if (!older_in) begin
                  holder_valid_in = 1'b1;
                  holder_slot_in  = idx_slot;
                  rc              = tfla_pkg::RC_OK;
               end else begin
                  rc = tfla_pkg::RC_REFUSED;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_strobe_in              = finish;
      rsp_in.result_code         = rc;
      rsp_in.granted_identity    = g_id;
      rsp_in.granted_slot        = g_slot;
      rsp_in.ticket_wrapped      = (ticket_in == '0);
      rsp_in.holder_identity     = '0;
      rsp_in.waiting_count       = '0;
      if (cmd_ff == tfla_pkg::CMD_STATUS && state_ff == ST_SCAN) begin
         rsp_in.holder_identity = act_in;
         rsp_in.waiting_count   = wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         issuing_ff      <= 1'b0;
         rd_live_ff      <= 1'b0;
         valid_ff        <= '0;
         ticket_ff       <= tfla_pkg::IDENT_W'(1);
         holder_valid_ff <= 1'b0;
         holder_slot_ff  <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         issuing_ff      <= issuing_in;
         rd_live_ff      <= rd_live_in;
         valid_ff        <= valid_in;
         ticket_ff       <= ticket_in;
         holder_valid_ff <= holder_valid_in;
         holder_slot_ff  <= holder_slot_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
      cmd_ff     <= cmd_in;
      ident_ff   <= ident_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      rd_idx_ff  <= rd_idx_in;
      rd_last_ff <= rd_last_in;
      older_ff   <= older_in;
      act_ff     <= act_in;
      wait_ff    <= wait_in;
      rsp_ff     <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_beat_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted beat neither answered nor in progress");

   a_holder_occupied: assert property (@(posedge clock) disable iff (reset)
      holder_valid_ff |-> valid_ff[holder_slot_ff])
      else $error("active holder slot is free");

   a_exhausted_sticky: assert property (@(posedge clock) disable iff (reset)
      (ticket_ff == '0) |=> (ticket_ff == '0))
      else $error("ticket counter left exhausted state");

endmodule
